/* rtl/ssm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared types, opcodes and status codes for the stack script machine.
// ----------------------------------------------------------------------------
package ssm_pkg;

   // opcodes
   localparam logic [4:0] OP_ADD   = 5'd0;
   localparam logic [4:0] OP_SUB   = 5'd1;
   localparam logic [4:0] OP_MUL   = 5'd2;
   localparam logic [4:0] OP_DIV   = 5'd3;
   localparam logic [4:0] OP_MOD   = 5'd4;
   localparam logic [4:0] OP_EQ    = 5'd5;
   localparam logic [4:0] OP_NE    = 5'd6;
   localparam logic [4:0] OP_GT    = 5'd7;
   localparam logic [4:0] OP_GE    = 5'd8;
   localparam logic [4:0] OP_LT    = 5'd9;
   localparam logic [4:0] OP_LE    = 5'd10;
   localparam logic [4:0] OP_AND   = 5'd11;
   localparam logic [4:0] OP_OR    = 5'd12;
   localparam logic [4:0] OP_XOR   = 5'd13;
   localparam logic [4:0] OP_SAR   = 5'd14;
   localparam logic [4:0] OP_SHL   = 5'd15;
   localparam logic [4:0] OP_NEG   = 5'd16;
   localparam logic [4:0] OP_NOT   = 5'd17;
   localparam logic [4:0] OP_PUSH  = 5'd18;
   localparam logic [4:0] OP_JUMP  = 5'd19;
   localparam logic [4:0] OP_BRZ   = 5'd20;
   localparam logic [4:0] OP_POPPC = 5'd21;
   localparam logic [4:0] OP_POPSL = 5'd22;
   localparam logic [4:0] OP_SPILL = 5'd23;
   localparam logic [4:0] OP_TICK  = 5'd24;
   localparam logic [4:0] OP_MASKA = 5'd25;
   localparam logic [4:0] OP_MASKD = 5'd28;

   // status codes
   localparam logic [2:0] ST_CONT  = 3'd0;
   localparam logic [2:0] ST_PC    = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;
   localparam logic [2:0] ST_STACK = 3'd4;
   localparam logic [2:0] ST_DIV0  = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_MASK_A = 3'd0;
   localparam logic [2:0] CSR_MASK_B = 3'd1;
   localparam logic [2:0] CSR_MASK_C = 3'd2;
   localparam logic [2:0] CSR_MASK_D = 3'd3;
   localparam logic [2:0] CSR_SPILL  = 3'd4;

   localparam int SLOT_COUNT = 8;

   typedef struct packed {
      logic [4:0]         cmd;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] top_value;
      logic [6:0]         stack_depth;
      logic [15:0]        program_counter;
      logic signed [31:0] slot_zero;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic       load;     // latch item, start stack reads
      logic       exec;     // evaluate non-divide ops, write back
      logic       div_start;
      logic       div_done_wb; // write quotient/remainder back
      logic       spill_step;  // push one slot
      logic       spill_end;   // finish spill
      logic       load_top;    // register new top value
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic       is_div;
      logic       is_spill;
      logic       div_busy;
      logic       spill_last;
   } sts_type;

endpackage

/* rtl/ssm_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_divider
// Radix-2 restoring divider for signed 32-bit truncating division.
// ----------------------------------------------------------------------------
module ssm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [31:0] quotient,
   output logic [31:0] remainder
);
   logic [31:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        qneg_ff, qneg_in, rneg_ff, rneg_in;
   logic [32:0] trial;

   // one quotient bit per cycle
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      qneg_in = qneg_ff; rneg_in = rneg_ff;
      trial = {r_ff[31:0], q_ff[31]} - {1'b0, d_ff};
      if (start) begin
         q_in    = dividend[31] ? 32'd0 - dividend : dividend;
         d_in    = divisor[31] ? 32'd0 - divisor : divisor;
         r_in    = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
         qneg_in = dividend[31] ^ divisor[31];
         rneg_in = dividend[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial;
         end else begin
            r_in = {r_ff[31:0], q_ff[31]};
         end
         q_in   = {q_ff[30:0], ~trial[32]};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in;
      qneg_ff <= qneg_in; rneg_ff <= rneg_in;
   end

   assign busy      = busy_ff;
   assign quotient  = qneg_ff ? 32'd0 - q_ff : q_ff;
   assign remainder = rneg_ff ? 32'd0 - r_ff[31:0] : r_ff[31:0];
endmodule

/* rtl/ssm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_datapath
// Operand stack memory, pc, result slots, masks and the execution unit.
// ----------------------------------------------------------------------------
module ssm_datapath #(
   parameter int STACK_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ssm_pkg::req_type  req_payload,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  ssm_pkg::ctl_type  ctl,
   output ssm_pkg::sts_type  sts,
   output ssm_pkg::rsp_type  rsp_payload
);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int SLOT_COUNT_L = ssm_pkg::SLOT_COUNT;

   logic [31:0] mem [STACK_DEPTH];
   logic [31:0] rd_a_ff, rd_b_ff;
   logic [4:0]  cmd_ff;
   logic [31:0] opnd_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [15:0] pc_ff, pc_in;
   logic [31:0] slot_ff [SLOT_COUNT_L];
   logic [31:0] mask_ff [4];
   logic        spd_ff;
   logic [2:0]  spidx_ff;
   logic [2:0]  st_ff, st_in;
   logic [31:0] top_ff, top_in;
   logic        we;
   logic [AW-1:0] wa;
   logic [31:0] wd;
   logic [31:0] res, b_res, t;
   logic [63:0] prod;
   logic        slt, sgt;
   logic [4:0]  sh;
   logic        dstart, dbusy;
   logic [31:0] quo, rem;
   logic [CW-1:0] n_m1, n_m2;
   logic [CW:0]   n_sp;

   ssm_divider u_div (
      .clock, .reset, .start(dstart), .dividend(rd_a_ff), .divisor(rd_b_ff),
      .busy(dbusy), .quotient(quo), .remainder(rem)
   );

   assign n_m1 = cnt_ff - CW'(1);
   assign n_m2 = cnt_ff - CW'(2);
   assign n_sp = {1'b0, cnt_ff} + (CW+1)'(8);
   assign t    = rd_b_ff;
   assign sh   = rd_b_ff[4:0];
   assign slt  = $signed(rd_a_ff) < $signed(rd_b_ff);
   assign sgt  = $signed(rd_a_ff) > $signed(rd_b_ff);
   assign prod = rd_a_ff * rd_b_ff;

   // binary op result
   always_comb begin
      case (cmd_ff)
         ssm_pkg::OP_ADD: b_res = rd_a_ff + rd_b_ff;
         ssm_pkg::OP_SUB: b_res = rd_a_ff - rd_b_ff;
         ssm_pkg::OP_MUL: b_res = prod[31:0];
         ssm_pkg::OP_EQ:  b_res = {31'd0, rd_a_ff == rd_b_ff};
         ssm_pkg::OP_NE:  b_res = {31'd0, rd_a_ff != rd_b_ff};
         ssm_pkg::OP_GT:  b_res = {31'd0, sgt};
         ssm_pkg::OP_GE:  b_res = {31'd0, !slt};
         ssm_pkg::OP_LT:  b_res = {31'd0, slt};
         ssm_pkg::OP_LE:  b_res = {31'd0, !sgt};
         ssm_pkg::OP_AND: b_res = rd_a_ff & rd_b_ff;
         ssm_pkg::OP_OR:  b_res = rd_a_ff | rd_b_ff;
         ssm_pkg::OP_XOR: b_res = rd_a_ff ^ rd_b_ff;
         ssm_pkg::OP_SAR: b_res = 32'($signed(rd_a_ff) >>> sh);
         ssm_pkg::OP_SHL: b_res = rd_a_ff << sh;
         default:         b_res = '0;
      endcase
   end
   assign res = b_res;

   // status to controller
   assign sts.is_div     = (cmd_ff == ssm_pkg::OP_DIV || cmd_ff == ssm_pkg::OP_MOD)
                           && cnt_ff >= CW'(2) && rd_b_ff != 32'd0;
   assign sts.is_spill   = cmd_ff == ssm_pkg::OP_SPILL && n_sp <= (CW+1)'(STACK_DEPTH);
   assign sts.div_busy   = dbusy;
   assign sts.spill_last = spidx_ff == 3'd7;
   assign dstart         = ctl.div_start;

   // execute: state updates, memory write
   always_comb begin
      cnt_in = cnt_ff; pc_in = pc_ff; st_in = st_ff; top_in = top_ff;
      we = 1'b0; wa = n_m1[AW-1:0]; wd = '0;
      if (ctl.exec) begin
         st_in = ssm_pkg::ST_CONT;
         if (cmd_ff <= ssm_pkg::OP_SHL) begin
            if (cnt_ff < CW'(2)) begin
               st_in = ssm_pkg::ST_STACK;
            end else if ((cmd_ff == ssm_pkg::OP_DIV || cmd_ff == ssm_pkg::OP_MOD)
                         && rd_b_ff == 32'd0) begin
               st_in = ssm_pkg::ST_DIV0;
            end else if (!(cmd_ff == ssm_pkg::OP_DIV || cmd_ff == ssm_pkg::OP_MOD)) begin
               we = 1'b1; wa = n_m2[AW-1:0]; wd = res; cnt_in = n_m1;
            end
         end else if (cmd_ff == ssm_pkg::OP_PUSH) begin
            if (cnt_ff >= CW'(STACK_DEPTH)) begin
               st_in = ssm_pkg::ST_STACK;
            end else begin
               we = 1'b1; wa = cnt_ff[AW-1:0]; wd = opnd_ff; cnt_in = cnt_ff + CW'(1);
            end
         end else if (cmd_ff == ssm_pkg::OP_JUMP) begin
            pc_in = pc_ff + opnd_ff[15:0]; st_in = ssm_pkg::ST_PC;
         end else if (cmd_ff == ssm_pkg::OP_SPILL) begin
            if (n_sp > (CW+1)'(STACK_DEPTH)) st_in = ssm_pkg::ST_STACK;
         end else if (cmd_ff <= ssm_pkg::OP_MASKD) begin
            if (cnt_ff == '0) begin
               st_in = ssm_pkg::ST_STACK;
            end else begin
               case (cmd_ff)
                  ssm_pkg::OP_NEG: begin we = 1'b1; wd = 32'd0 - t; end
                  ssm_pkg::OP_NOT: begin we = 1'b1; wd = ~t; end
                  ssm_pkg::OP_BRZ: begin
                     cnt_in = n_m1;
                     if (t == 32'd0) begin
                        pc_in = pc_ff + opnd_ff[15:0]; st_in = ssm_pkg::ST_PC;
                     end
                  end
                  ssm_pkg::OP_POPPC: begin
                     cnt_in = n_m1; pc_in = t[15:0]; st_in = ssm_pkg::ST_PC;
                  end
                  ssm_pkg::OP_POPSL: cnt_in = n_m1;
                  ssm_pkg::OP_TICK: begin
                     we = 1'b1; wd = t - 32'd1;
                     if (t == 32'd1) begin
                        cnt_in = n_m1; st_in = ssm_pkg::ST_DONE;
                     end else begin
                        st_in = ssm_pkg::ST_WAIT;
                     end
                  end
                  default: cnt_in = n_m1;
               endcase
            end
         end
      end else if (ctl.div_done_wb) begin
         we = 1'b1; wa = n_m2[AW-1:0];
         wd = (cmd_ff == ssm_pkg::OP_DIV) ? quo : rem;
         cnt_in = n_m1;
      end else if (ctl.spill_step) begin
         we = 1'b1; wa = cnt_ff[AW-1:0]; wd = slot_ff[spidx_ff];
         cnt_in = cnt_ff + CW'(1);
      end
      // top of stack after the write, from the register file
      if (ctl.load_top) top_in = (cnt_ff == '0) ? 32'd0 : rd_b_ff;
   end

   // memory and read ports
   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      if (ctl.load) begin
         rd_a_ff <= mem[n_m2[AW-1:0]];
         cmd_ff  <= req_payload.cmd;
         opnd_ff <= req_payload.operand;
      end else begin
         rd_b_ff <= mem[n_m1[AW-1:0]];
      end
      if (ctl.load) rd_b_ff <= mem[n_m1[AW-1:0]];
      top_ff <= top_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         pc_ff    <= '0;
         st_ff    <= ssm_pkg::ST_CONT;
         spd_ff   <= 1'b0;
         spidx_ff <= '0;
         for (int i = 0; i < SLOT_COUNT_L; i++) slot_ff[i] <= '0;
         for (int i = 0; i < 4; i++) mask_ff[i] <= '0;
      end else begin
         cnt_ff <= cnt_in;
         pc_ff  <= pc_in;
         st_ff  <= st_in;
         if (csr_write) begin
            case (csr_index)
               ssm_pkg::CSR_MASK_A: mask_ff[0] <= csr_data;
               ssm_pkg::CSR_MASK_B: mask_ff[1] <= csr_data;
               ssm_pkg::CSR_MASK_C: mask_ff[2] <= csr_data;
               ssm_pkg::CSR_MASK_D: mask_ff[3] <= csr_data;
               ssm_pkg::CSR_SPILL:  spd_ff     <= csr_data[0];
               default: ;
            endcase
         end
         if (ctl.exec && cnt_ff != '0) begin
            if (cmd_ff == ssm_pkg::OP_POPSL) slot_ff[opnd_ff[2:0]] <= t;
            if (cmd_ff >= ssm_pkg::OP_MASKA && cmd_ff <= ssm_pkg::OP_MASKD)
               slot_ff[0] <= {31'd0, (mask_ff[cmd_ff[1:0] - 2'd1] & t) != 32'd0};
         end
         // spill: step through the slots, then clear them and re-arm slot 0
         if (ctl.spill_end) begin
            spidx_ff <= '0;
            for (int i = 0; i < SLOT_COUNT_L; i++)
               slot_ff[i] <= (i == 0) ? {31'd0, spd_ff} : 32'd0;
         end else if (ctl.spill_step) begin
            spidx_ff <= spidx_ff + 3'd1;
         end
      end
   end

   assign rsp_payload.status          = st_ff;
   assign rsp_payload.top_value       = top_ff;
   assign rsp_payload.stack_depth     = 7'(cnt_ff);
   assign rsp_payload.program_counter = pc_ff;
   assign rsp_payload.slot_zero       = slot_ff[0];
endmodule

/* rtl/ssm_control.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_control
// Sequencer: fetch, execute, divide wait, spill and response handshake.
// ----------------------------------------------------------------------------
module ssm_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  ssm_pkg::sts_type sts,
   output ssm_pkg::ctl_type ctl
);
   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_DIVW, S_DIVWB, S_SPILL, S_READ, S_TOP, S_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl = '0;
      case (state_ff)
         S_IDLE:  ctl.load = req_valid;
         S_EXEC:  begin
            ctl.exec      = 1'b1;
            ctl.div_start = sts.is_div;
         end
         S_DIVWB: ctl.div_done_wb = 1'b1;
         S_SPILL: begin
            ctl.spill_step = 1'b1;
            ctl.spill_end  = sts.spill_last;
         end
         S_TOP:   ctl.load_top = 1'b1;
         default: ;
      endcase
   end

   // S_READ re-reads the top entry once the last write has landed
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE:  if (req_valid) state_ff <= S_EXEC;
            S_EXEC:  begin
               if (sts.is_div)        state_ff <= S_DIVW;
               else if (sts.is_spill) state_ff <= S_SPILL;
               else                   state_ff <= S_READ;
            end
            S_DIVW:  if (!sts.div_busy) state_ff <= S_DIVWB;
            S_DIVWB: state_ff <= S_READ;
            S_SPILL: if (sts.spill_last) state_ff <= S_READ;
            S_READ:  state_ff <= S_TOP;
            S_TOP:   begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP:  if (rsp_ready) begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* rtl/stack_script_machine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_script_machine_core
// Script opcode executor on a 32-bit operand stack with pc and result slots.
// ----------------------------------------------------------------------------
//  channel | ports                       | direction
//  req     | req_valid/req_ready/req_data | in : opcode and operand
//  rsp     | rsp_valid/rsp_ready/rsp_data | out: status, top, depth, pc, slot 0
//  csr     | csr_write/csr_index/csr_data | in : mask and spill registers
//
//  Simple opcodes pass through the execute, read and top states before
//  the result is offered; divide and modulo also wait on the
//  one-bit-per-cycle divider and write back; spill makes one stack
//  write per slot. The next request is taken in the cycle after the
//  result transaction. Reset is synchronous and needs no clearing pass.
//  A waiting result holds the block until it is taken.
// ----------------------------------------------------------------------------
module stack_script_machine_core #(
   parameter int STACK_DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ssm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ssm_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);
   ssm_pkg::ctl_type ctl;
   ssm_pkg::sts_type sts;

   ssm_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .ctl
   );

   ssm_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .req_payload(req_data), .csr_write, .csr_index, .csr_data,
      .ctl, .sts, .rsp_payload(rsp_data)
   );

   // no new transaction while a result is pending
   a_one_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");

   // depth never exceeds the stack
   a_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.stack_depth <= 7'(STACK_DEPTH))
      else $error("depth overflow");

   // status codes stay in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ssm_pkg::ST_DIV0) else $error("bad status");
endmodule
